// ===== rtl/mcdlp_pkg.sv =====
// Shared types and constants for the multi-channel debouncer with long press.
package mcdlp_pkg;

  localparam int MaxChannels     = 8;
  localparam int ChannelsDef     = 8;
  localparam int CountWidthDef   = 8;
  localparam int FiltW           = 8;
  localparam int StateW          = 2;
  localparam int CfgDataW        = 64;
  localparam int CfgIdxW         = 8;
  localparam int ActiveW         = 4;
  localparam int PinW            = MaxChannels;
  localparam int StatesW         = StateW * MaxChannels;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPressFilters    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegReleaseFilters  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegLongPressLimits = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegActiveChannels  = CfgIdxW'(3);

  typedef enum logic [StateW-1:0] {
    StReleased = 2'd0,
    StPressed  = 2'd1,
    StLong     = 2'd2
  } state_e;

  // Per-channel thresholds
  typedef struct packed {
    logic [FiltW-1:0] press_filt;
    logic [FiltW-1:0] release_filt;
    logic [FiltW-1:0] long_limit;
  } chan_cfg_t;

endpackage

// ===== rtl/mcdlp_channel.sv =====
// One debouncer channel: state, qualify counter and next-state logic.
module mcdlp_channel #(
  parameter int COUNT_WIDTH = mcdlp_pkg::CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   active_i,
  input  logic                   level_i,
  input  mcdlp_pkg::chan_cfg_t   cfg_i,
  output mcdlp_pkg::state_e      state_d_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  mcdlp_pkg::state_e       state_q, state_d;
  logic [COUNT_WIDTH-1:0]  count_q, count_d;
  logic [COUNT_WIDTH-1:0]  count_inc;
  logic [mcdlp_pkg::FiltW-1:0] count_ext;

  // saturating increment
  assign count_inc = (count_q == CntMax) ? CntMax : count_q + COUNT_WIDTH'(1);
  assign count_ext = mcdlp_pkg::FiltW'(count_inc);

  always_comb begin
    state_d = mcdlp_pkg::StReleased;
    count_d = '0;
    if (active_i) begin
      unique case (state_q)
        mcdlp_pkg::StReleased: begin
          if (level_i) begin
            if (count_ext > cfg_i.press_filt) begin
              state_d = mcdlp_pkg::StPressed;
            end else begin
              count_d = count_inc;
            end
          end
        end
        mcdlp_pkg::StPressed, mcdlp_pkg::StLong: begin
          state_d = state_q;
          if (!level_i) begin
            if (count_ext > cfg_i.release_filt) begin
              state_d = mcdlp_pkg::StReleased;
            end else begin
              count_d = count_inc;
            end
          end else if (state_q == mcdlp_pkg::StPressed && cfg_i.long_limit != '0) begin
            // held press counts toward long press on the shared counter
            if (count_ext > cfg_i.long_limit) begin
              state_d = mcdlp_pkg::StLong;
            end else begin
              count_d = count_inc;
            end
          end
        end
        default: begin
          state_d = mcdlp_pkg::StReleased;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcdlp_pkg::StReleased;
      count_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign state_d_o = state_d;

  a_inactive_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !active_i |=> state_q == mcdlp_pkg::StReleased && count_q == '0)
    else $error("inactive channel not held at reset");

  a_no_long_from_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && state_q == mcdlp_pkg::StReleased |=> state_q != mcdlp_pkg::StLong)
    else $error("released channel jumped to long press");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(state_q) && $stable(count_q))
    else $error("channel state moved without a request");

  a_long_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcdlp_pkg::StLong && $past(state_q) == mcdlp_pkg::StPressed
      |-> count_q == '0)
    else $error("counter not cleared on long-press entry");

endmodule

// ===== rtl/multi_channel_debounce_long_press.sv =====
// Top level of the multi-channel push-button debouncer with long press.
//
//   port group   dir  handshake                 payload
//   input        in   in_valid_i / in_ready_o   pin_levels_i[7:0]
//   result       out  out_valid_o / out_ready_i channel_states_o[15:0]
//   config       in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i[63:0]
//
// One request per cycle sustained while out_ready_i is high.
// An input register feeds the parallel channel logic, which loads the result
// register and the channel state in the same edge.
// Reset clears all channel states, counters, configuration and valid flags.
// A stalled result holds the input register; in_ready_o drops only when both
// the input and result registers are full and the result is not taken.
module multi_channel_debounce_long_press #(
  parameter int CHANNELS    = mcdlp_pkg::ChannelsDef,
  parameter int COUNT_WIDTH = mcdlp_pkg::CountWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mcdlp_pkg::PinW-1:0]        pin_levels_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcdlp_pkg::StatesW-1:0]     channel_states_o,
  input  logic                              cfg_we_i,
  input  logic [mcdlp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mcdlp_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [mcdlp_pkg::CfgDataW-1:0] press_q, release_q, long_q;
  logic [mcdlp_pkg::ActiveW-1:0]  active_q, active_n;

  logic                            s1_valid_q;
  logic [CHANNELS-1:0]             pins_q;
  logic                            advance;
  logic                            out_valid_q;
  logic [mcdlp_pkg::StatesW-1:0]   states_q, states_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= '0;
      release_q <= '0;
      long_q    <= '0;
      active_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcdlp_pkg::RegPressFilters:    press_q   <= cfg_wdata_i;
        mcdlp_pkg::RegReleaseFilters:  release_q <= cfg_wdata_i;
        mcdlp_pkg::RegLongPressLimits: long_q    <= cfg_wdata_i;
        mcdlp_pkg::RegActiveChannels:  active_q  <= cfg_wdata_i[mcdlp_pkg::ActiveW-1:0];
        default: ;
      endcase
    end
  end

  assign active_n = (active_q > mcdlp_pkg::ActiveW'(CHANNELS))
                    ? mcdlp_pkg::ActiveW'(CHANNELS) : active_q;

  // input register moves to the result register when that is free or taken
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pins_q <= pin_levels_i[CHANNELS-1:0];
    end
    if (advance) begin
      states_q <= states_d;
    end
  end

  for (genvar i = 0; i < mcdlp_pkg::MaxChannels; i++) begin : g_ch
    if (i < CHANNELS) begin : g_used
      mcdlp_pkg::chan_cfg_t ch_cfg;
      mcdlp_pkg::state_e    ch_state_d;

      assign ch_cfg.press_filt   = press_q[mcdlp_pkg::FiltW*i +: mcdlp_pkg::FiltW];
      assign ch_cfg.release_filt = release_q[mcdlp_pkg::FiltW*i +: mcdlp_pkg::FiltW];
      assign ch_cfg.long_limit   = long_q[mcdlp_pkg::FiltW*i +: mcdlp_pkg::FiltW];

      mcdlp_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_channel (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .advance_i (advance),
        .active_i  (mcdlp_pkg::ActiveW'(i) < active_n),
        .level_i   (pins_q[i]),
        .cfg_i     (ch_cfg),
        .state_d_o (ch_state_d)
      );

      assign states_d[mcdlp_pkg::StateW*i +: mcdlp_pkg::StateW] = ch_state_d;
    end else begin : g_unused
      assign states_d[mcdlp_pkg::StateW*i +: mcdlp_pkg::StateW] = '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_states_o = states_q;

endmodule
